### rtl/core/ugnv_pkg.sv
// Shared constants, payload types and cell indexing for the uniform grid nearest-vertex block.
package ugnv_pkg;

	localparam int MAX_POINTS   = 4096;
	localparam int MAX_GRID_DIM = 32;
	localparam int COORD_BITS   = 24;

	localparam int ID_W       = 12;
	localparam int DSQ_W      = 50;
	localparam int CFG_W      = 24;
	localparam int GDIM_W     = 6;
	localparam int RECIP_W    = 16;
	localparam int RECIP_FRAC = 16;

	localparam int PT_AW      = $clog2(MAX_POINTS);
	localparam int PT_DEPTH   = 1 << PT_AW;
	localparam int CELL_BITS  = $clog2(MAX_GRID_DIM);
	localparam int CELL_AW    = 3 * CELL_BITS;
	localparam int CELL_DEPTH = 1 << CELL_AW;
	localparam int DIM_W      = $clog2(MAX_GRID_DIM + 1);
	localparam int OFF_W      = DIM_W + 1;
	localparam int CC_W       = COORD_BITS + 2;
	localparam int DIST_W     = 2 * COORD_BITS + 4;
	localparam int SWEEP_N    = (CELL_DEPTH > PT_DEPTH) ? CELL_DEPTH : PT_DEPTH;
	localparam int SWEEP_W    = $clog2(SWEEP_N);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] REG_GRID_DIM    = 2'd0;
	localparam logic [1:0] REG_GRID_ORIGIN = 2'd1;
	localparam logic [1:0] REG_CELL_RECIP  = 2'd2;

	typedef struct packed {
		logic [1:0]                   action;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic [ID_W-1:0]              point_id;
	} in_t;

	typedef struct packed {
		logic             hit;
		logic [ID_W-1:0]  nearest_id;
		logic [DSQ_W-1:0] best_dist_sq;
	} out_t;

	typedef struct packed {
		logic             used;
		logic [PT_AW-1:0] head;
		logic [PT_AW-1:0] tail;
	} head_t;

	typedef struct packed {
		logic                         used;
		logic                         nv;
		logic [PT_AW-1:0]             next;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pt_t;

	// linear cell index x + y*d + z*d*d
	function automatic logic [CELL_AW-1:0] cell_lin(input logic [CELL_BITS-1:0] x,
		input logic [CELL_BITS-1:0] y, input logic [CELL_BITS-1:0] z,
		input logic [DIM_W-1:0] d, input logic [2*DIM_W-1:0] dd);
		logic [CELL_BITS+2*DIM_W:0] s;
		s = (CELL_BITS+2*DIM_W+1)'(x)
			+ (CELL_BITS+2*DIM_W+1)'(y) * (CELL_BITS+2*DIM_W+1)'(d)
			+ (CELL_BITS+2*DIM_W+1)'(z) * (CELL_BITS+2*DIM_W+1)'(dd);
		return s[CELL_AW-1:0];
	endfunction

endpackage

### rtl/core/ugnv_ram.sv
// Generic simple dual-port RAM with registered read.
module ugnv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/ugnv_cell_calc.sv
// Position to cell coordinate: subtract origin, scale by reciprocal, floor.
module ugnv_cell_calc (
	input  logic                                    clk,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0]  pos_x,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0]  pos_y,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0]  pos_z,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0]  origin,
	input  logic [ugnv_pkg::RECIP_W-1:0]            recip,
	output logic signed [ugnv_pkg::CC_W-1:0]        cell_x,
	output logic signed [ugnv_pkg::CC_W-1:0]        cell_y,
	output logic signed [ugnv_pkg::CC_W-1:0]        cell_z
);
	import ugnv_pkg::*;

	localparam int PW = COORD_BITS + RECIP_W + 2;

	logic signed [CC_W-1:0] cell_x_q, cell_y_q, cell_z_q;

	function automatic logic signed [CC_W-1:0] to_cell(input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] o, input logic [RECIP_W-1:0] rc);
		logic signed [COORD_BITS:0] diff;
		logic signed [PW-1:0]       prod;
		diff = (COORD_BITS+1)'(p) - (COORD_BITS+1)'(o);
		prod = PW'(diff) * $signed({1'b0, rc});
		// arithmetic shift gives floor for negative offsets
		return prod[PW-1:RECIP_FRAC];
	endfunction

	always_ff @(posedge clk) begin
		cell_x_q <= to_cell(pos_x, origin, recip);
		cell_y_q <= to_cell(pos_y, origin, recip);
		cell_z_q <= to_cell(pos_z, origin, recip);
	end

	assign cell_x = cell_x_q;
	assign cell_y = cell_y_q;
	assign cell_z = cell_z_q;
endmodule

### rtl/core/ugnv_dist.sv
// Two-stage squared distance: three squares, then their sum.
module ugnv_dist (
	input  logic                                   clk,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] pt_x,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] pt_y,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] pt_z,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] q_x,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] q_y,
	input  logic signed [ugnv_pkg::COORD_BITS-1:0] q_z,
	output logic [ugnv_pkg::DIST_W-1:0]            dist_sq
);
	import ugnv_pkg::*;

	localparam int SQ_W = 2 * (COORD_BITS + 1);

	logic [SQ_W-1:0]   sq_x_s1, sq_y_s1, sq_z_s1;
	logic [DIST_W-1:0] sum_s2;

	function automatic logic [COORD_BITS:0] mag(input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b);
		logic signed [COORD_BITS:0] df;
		df = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
		return df[COORD_BITS] ? (COORD_BITS+1)'(-df) : (COORD_BITS+1)'(df);
	endfunction

	always_ff @(posedge clk) begin
		sq_x_s1 <= SQ_W'(mag(pt_x, q_x)) * SQ_W'(mag(pt_x, q_x));
		sq_y_s1 <= SQ_W'(mag(pt_y, q_y)) * SQ_W'(mag(pt_y, q_y));
		sq_z_s1 <= SQ_W'(mag(pt_z, q_z)) * SQ_W'(mag(pt_z, q_z));
		sum_s2  <= DIST_W'(sq_x_s1) + DIST_W'(sq_y_s1) + DIST_W'(sq_z_s1);
	end

	assign dist_sq = sum_s2;
endmodule

### rtl/core/uniform_grid_nearest_vertex_top.sv
// Uniform grid nearest-vertex block: bucket store, insert, clear and nearest query.
//
// Input words (in_valid/in_ready) carry an action and a position: insert stores
// point_id at the position and appends it to its cell list, query returns the
// nearest stored point of the query cell or of the first nonempty ring around
// it, clear empties the grid. Every word yields one output word
// (out_valid/out_ready) from an output register.
// Cell heads live in a 32768-entry RAM and points with their links in a
// 4096-entry RAM; both have registered reads.
// One word is in flight at a time; in_ready rises again the cycle after the
// result is registered. An insert also writes the old tail's link when the
// cell already holds points; clear sweeps both RAMs. A query reads its own
// cell unless that cell lies outside the grid, walks each stored point of
// a visited cell, and visits the cells on each ring in turn, skipping the
// interior rows; it stops after the first ring that yields a point.
// After reset the same sweep runs with in_ready low;
// configuration writes are taken at any time.
// A stalled receiver holds the output word; the next word is accepted and
// processed, and its result waits until the output register frees.
module uniform_grid_nearest_vertex_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ugnv_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ugnv_pkg::out_t                out_data,
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [ugnv_pkg::CFG_W-1:0]    wr_data
);
	import ugnv_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_MUL, S_CELL, S_INS_CHK, S_INS_TAIL, S_HEAD_CHK,
		S_W_DAT, S_W_SQ, S_W_CMP, S_CELL_DONE, S_RING_INIT, S_RING_CELL,
		S_RING_ADV, S_RING_END, S_OUT
	} state_t;

	typedef struct packed {
		logic                    empty;
		logic signed [OFF_W-1:0] lo;
		logic signed [OFF_W-1:0] hi;
	} span_t;

	localparam int BW = CC_W + 2;

	state_t state_q;
	in_t    item_q;
	out_t   res_q, out_q;
	logic   out_valid_q;

	logic [GDIM_W-1:0]            grid_dim_q;
	logic signed [COORD_BITS-1:0] origin_q;
	logic [RECIP_W-1:0]           recip_q;
	logic [DIM_W-1:0]             d_eff;
	logic [2*DIM_W-1:0]           dd_q;

	logic signed [CC_W-1:0] cx, cy, cz;
	logic [DIST_W-1:0]      dist_sq;

	logic [SWEEP_W-1:0]      sweep_cnt_q;
	logic                    sweep_res_q;
	logic [CELL_AW-1:0]      lin_q;
	logic                    own_ok_q;
	logic [PT_AW-1:0]        tail_q;
	logic [DIM_W-1:0]        r_q;
	logic signed [OFF_W-1:0] dx_q, dy_q, dz_q;
	logic signed [OFF_W-1:0] x1_q, y0_q, y1_q, z0_q, z1_q;
	logic                    in_ring_q;
	logic                    found_q;
	logic [PT_AW-1:0]        best_id_q;
	logic [DIST_W-1:0]       best_d_q;
	logic [PT_AW-1:0]        cur_id_q;
	logic                    nv_q;
	logic [PT_AW-1:0]        next_q;

	logic               head_we;
	logic [CELL_AW-1:0] head_waddr, head_raddr;
	head_t              head_wdata, head_rd;
	logic               pt_we;
	logic [PT_AW-1:0]   pt_waddr, pt_raddr;
	pt_t                pt_wdata, pt_rd;

	logic                    own_ok, pid_ok, on_ring;
	logic [CELL_AW-1:0]      own_lin, ring_lin;
	logic [PT_AW-1:0]        pid_addr;
	logic signed [OFF_W-1:0] r_s;
	logic [CELL_BITS-1:0]    rx, ry, rz;
	span_t                   sp_x, sp_y, sp_z;

	ugnv_cell_calc u_cell (
		.clk    (clk),
		.pos_x  (item_q.pos_x),
		.pos_y  (item_q.pos_y),
		.pos_z  (item_q.pos_z),
		.origin (origin_q),
		.recip  (recip_q),
		.cell_x (cx),
		.cell_y (cy),
		.cell_z (cz)
	);

	ugnv_dist u_dist (
		.clk     (clk),
		.pt_x    (pt_rd.x),
		.pt_y    (pt_rd.y),
		.pt_z    (pt_rd.z),
		.q_x     (item_q.pos_x),
		.q_y     (item_q.pos_y),
		.q_z     (item_q.pos_z),
		.dist_sq (dist_sq)
	);

	ugnv_ram #(.WIDTH($bits(head_t)), .DEPTH(CELL_DEPTH)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rd)
	);

	ugnv_ram #(.WIDTH($bits(pt_t)), .DEPTH(PT_DEPTH)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	function automatic logic cell_in(input logic signed [CC_W-1:0] c, input logic [DIM_W-1:0] d);
		return !c[CC_W-1] && (c < CC_W'(d));
	endfunction

	// clip the ring offsets [-r, r] to the grid along one axis
	function automatic span_t ring_span(input logic signed [CC_W-1:0] c,
		input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] d);
		logic signed [BW-1:0] rs, ncx, lo, t, hi;
		span_t sp;
		rs  = $signed(BW'(r));
		ncx = -BW'(c);
		lo  = (ncx > -rs) ? ncx : -rs;
		t   = $signed(BW'(d)) - $signed(BW'(1)) - BW'(c);
		hi  = (t < rs) ? t : rs;
		sp.empty = lo > hi;
		sp.lo    = lo[OFF_W-1:0];
		sp.hi    = hi[OFF_W-1:0];
		return sp;
	endfunction

	always_comb begin
		if (grid_dim_q == '0) begin
			d_eff = DIM_W'(1);
		end else if (32'(grid_dim_q) > MAX_GRID_DIM) begin
			d_eff = DIM_W'(MAX_GRID_DIM);
		end else begin
			d_eff = DIM_W'(grid_dim_q);
		end
	end

	assign own_ok   = cell_in(cx, d_eff) && cell_in(cy, d_eff) && cell_in(cz, d_eff);
	assign own_lin  = cell_lin(cx[CELL_BITS-1:0], cy[CELL_BITS-1:0], cz[CELL_BITS-1:0],
		d_eff, dd_q);
	assign pid_ok   = 32'(item_q.point_id) < MAX_POINTS;
	assign pid_addr = PT_AW'(item_q.point_id);
	assign r_s      = $signed(OFF_W'(r_q));
	assign on_ring  = (dx_q == r_s) || (dx_q == -r_s) || (dy_q == r_s) || (dy_q == -r_s)
		|| (dz_q == r_s) || (dz_q == -r_s);
	assign rx       = CELL_BITS'(cx[CELL_BITS-1:0] + dx_q[CELL_BITS-1:0]);
	assign ry       = CELL_BITS'(cy[CELL_BITS-1:0] + dy_q[CELL_BITS-1:0]);
	assign rz       = CELL_BITS'(cz[CELL_BITS-1:0] + dz_q[CELL_BITS-1:0]);
	assign ring_lin = cell_lin(rx, ry, rz, d_eff, dd_q);
	assign sp_x     = ring_span(cx, r_q, d_eff);
	assign sp_y     = ring_span(cy, r_q, d_eff);
	assign sp_z     = ring_span(cz, r_q, d_eff);

	// RAM ports
	always_comb begin
		head_we    = 1'b0;
		head_waddr = lin_q;
		head_wdata = '0;
		head_raddr = '0;
		pt_we      = 1'b0;
		pt_waddr   = pid_addr;
		pt_wdata   = '0;
		pt_raddr   = '0;
		case (state_q)
			S_SWEEP: begin
				head_waddr = CELL_AW'(sweep_cnt_q);
				pt_waddr   = PT_AW'(sweep_cnt_q);
				head_we    = 32'(sweep_cnt_q) < CELL_DEPTH;
				pt_we      = 32'(sweep_cnt_q) < PT_DEPTH;
			end
			S_CELL: begin
				head_raddr = own_lin;
				pt_raddr   = pid_addr;
			end
			S_INS_CHK: begin
				if (pid_ok && !pt_rd.used && own_ok_q) begin
					pt_we          = 1'b1;
					pt_wdata.used  = 1'b1;
					pt_wdata.x     = item_q.pos_x;
					pt_wdata.y     = item_q.pos_y;
					pt_wdata.z     = item_q.pos_z;
					head_we        = 1'b1;
					head_wdata.used = 1'b1;
					head_wdata.tail = pid_addr;
					head_wdata.head = head_rd.used ? head_rd.head : pid_addr;
					pt_raddr       = head_rd.tail;
				end
			end
			S_INS_TAIL: begin
				pt_we         = 1'b1;
				pt_waddr      = tail_q;
				pt_wdata      = pt_rd;
				pt_wdata.nv   = 1'b1;
				pt_wdata.next = pid_addr;
			end
			S_HEAD_CHK: begin
				pt_raddr = head_rd.head;
			end
			S_W_CMP: begin
				pt_raddr = next_q;
			end
			S_RING_CELL: begin
				head_raddr = ring_lin;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_cnt_q <= '0;
			sweep_res_q <= 1'b0;
			out_valid_q <= 1'b0;
			grid_dim_q  <= GDIM_W'(1);
			origin_q    <= '0;
			recip_q     <= RECIP_W'(1);
			found_q     <= 1'b0;
			in_ring_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_GRID_DIM:    grid_dim_q <= wr_data[GDIM_W-1:0];
					REG_GRID_ORIGIN: origin_q   <= $signed(wr_data[COORD_BITS-1:0]);
					REG_CELL_RECIP:  recip_q    <= wr_data[RECIP_W-1:0];
					default: begin
					end
				endcase
			end
			// the output state refills the register itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
					if (32'(sweep_cnt_q) == SWEEP_N - 1) begin
						state_q <= sweep_res_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					found_q   <= 1'b0;
					in_ring_q <= 1'b0;
					res_q     <= '0;
					state_q   <= S_CELL;
				end
				S_CELL: begin
					lin_q    <= own_lin;
					own_ok_q <= own_ok;
					case (item_q.action)
						ACT_INSERT: state_q <= S_INS_CHK;
						ACT_QUERY:  state_q <= own_ok ? S_HEAD_CHK : S_CELL_DONE;
						ACT_CLEAR: begin
							sweep_cnt_q <= '0;
							sweep_res_q <= 1'b1;
							state_q     <= S_SWEEP;
						end
						default:    state_q <= S_OUT;
					endcase
				end
				S_INS_CHK: begin
					tail_q <= head_rd.tail;
					if (pid_ok && !pt_rd.used && own_ok_q) begin
						res_q.hit        <= 1'b1;
						res_q.nearest_id <= item_q.point_id;
						state_q          <= head_rd.used ? S_INS_TAIL : S_OUT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_INS_TAIL: begin
					state_q <= S_OUT;
				end
				S_HEAD_CHK: begin
					cur_id_q <= head_rd.head;
					state_q  <= head_rd.used ? S_W_DAT : S_CELL_DONE;
				end
				S_W_DAT: begin
					nv_q    <= pt_rd.nv;
					next_q  <= pt_rd.next;
					state_q <= S_W_SQ;
				end
				S_W_SQ: begin
					state_q <= S_W_CMP;
				end
				S_W_CMP: begin
					// strict compare: the first point met keeps a tie
					if (!found_q || dist_sq < best_d_q) begin
						found_q   <= 1'b1;
						best_d_q  <= dist_sq;
						best_id_q <= cur_id_q;
					end
					if (nv_q) begin
						cur_id_q <= next_q;
						state_q  <= S_W_DAT;
					end else begin
						state_q <= S_CELL_DONE;
					end
				end
				S_CELL_DONE: begin
					if (in_ring_q) begin
						state_q <= S_RING_ADV;
					end else if (found_q || d_eff <= DIM_W'(1)) begin
						state_q <= S_RING_END;
					end else begin
						r_q       <= DIM_W'(1);
						in_ring_q <= 1'b1;
						state_q   <= S_RING_INIT;
					end
				end
				S_RING_INIT: begin
					x1_q <= sp_x.hi;
					y0_q <= sp_y.lo;
					y1_q <= sp_y.hi;
					z0_q <= sp_z.lo;
					z1_q <= sp_z.hi;
					dx_q <= sp_x.lo;
					dy_q <= sp_y.lo;
					dz_q <= sp_z.lo;
					state_q <= (sp_x.empty || sp_y.empty || sp_z.empty) ? S_RING_END
						: S_RING_CELL;
				end
				S_RING_CELL: begin
					if (on_ring) begin
						state_q <= S_HEAD_CHK;
					end else if (r_s <= z1_q) begin
						// interior row: only the far face remains
						dz_q <= r_s;
					end else begin
						dz_q    <= z1_q;
						state_q <= S_RING_ADV;
					end
				end
				S_RING_ADV: begin
					state_q <= S_RING_CELL;
					if (dz_q != z1_q) begin
						dz_q <= dz_q + 1'b1;
					end else begin
						dz_q <= z0_q;
						if (dy_q != y1_q) begin
							dy_q <= dy_q + 1'b1;
						end else begin
							dy_q <= y0_q;
							if (dx_q != x1_q) begin
								dx_q <= dx_q + 1'b1;
							end else begin
								state_q <= S_RING_END;
							end
						end
					end
				end
				S_RING_END: begin
					if (!found_q && in_ring_q && (r_q + 1'b1) < d_eff) begin
						r_q     <= r_q + 1'b1;
						state_q <= S_RING_INIT;
					end else begin
						res_q.hit          <= found_q;
						res_q.nearest_id   <= found_q ? ID_W'(best_id_q) : '0;
						res_q.best_dist_sq <= found_q ? best_d_q[DSQ_W-1:0] : '0;
						state_q            <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= sweep_res_q ? '0 : res_q;
						sweep_res_q <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dd_q <= (2*DIM_W)'(d_eff) * (2*DIM_W)'(d_eff);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
